// ===== rtl/core/kcl_pkg.sv =====
// Shared types and constants for the keyed compacting list.
// No dependencies; imported by kcl_cell and keyed_compacting_list.
`default_nettype none

package kcl_pkg;

    localparam int KEY_W      = 64;
    localparam int PAYLOAD_W  = 64;
    localparam int COUNT_W    = 6;
    localparam int CAPACITY_D = 32;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_EXEC = 2'b10
    } fsm_t;

    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        op_t  op;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/kcl_cell.sv =====
// One table slot of the keyed compacting list: key, payload, occupancy, match flag.
// Depends on kcl_pkg; instantiated in a row by keyed_compacting_list.
`default_nettype none

module kcl_cell (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire kcl_pkg::cell_ctrl_t                ctrl,
    input  wire logic [kcl_pkg::KEY_W-1:0]          cmp_key,
    input  wire logic [kcl_pkg::KEY_W-1:0]          wr_key,
    input  wire logic [kcl_pkg::PAYLOAD_W-1:0]      wr_payload,
    input  wire logic                               prev_occ,
    input  wire logic                               next_occ,
    input  wire logic [kcl_pkg::KEY_W-1:0]          next_key,
    input  wire logic [kcl_pkg::PAYLOAD_W-1:0]      next_payload,
    input  wire logic                               hit_in,
    output logic                                    hit_out,
    output logic                                    occ,
    output logic [kcl_pkg::KEY_W-1:0]               key_q,
    output logic [kcl_pkg::PAYLOAD_W-1:0]           payload_q
);
    import kcl_pkg::*;

    logic                  occ_reg;
    logic                  occ_next;
    logic                  match_reg;
    logic                  match_next;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      key_next;
    logic [PAYLOAD_W-1:0]  payload_reg;
    logic [PAYLOAD_W-1:0]  payload_next;
    logic                  kill;

    assign kill    = hit_in | match_reg;
    assign hit_out = kill;

    always_comb
    begin
        match_next   = match_reg;
        occ_next     = occ_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.cmp_en)
        begin
            match_next = occ_reg && (key_reg == cmp_key);
        end
        if (ctrl.upd_en)
        begin
            match_next = 1'b0;
            case (ctrl.op)
                OP_APPEND:
                begin
                    if (!occ_reg && prev_occ)
                    begin
                        occ_next     = 1'b1;
                        key_next     = wr_key;
                        payload_next = wr_payload;
                    end
                end
                OP_DELETE:
                begin
                    // shift up from the first match toward the tail
                    if (kill)
                    begin
                        occ_next     = next_occ;
                        key_next     = next_key;
                        payload_next = next_payload;
                    end
                end
                OP_CLEAR:
                begin
                    occ_next = 1'b0;
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            occ_reg   <= occ_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign occ       = occ_reg;
    assign key_q     = key_reg;
    assign payload_q = payload_reg;

endmodule

`default_nettype wire

// ===== rtl/core/keyed_compacting_list.sv =====
// Keyed compacting list: ordered table of key/payload entries with append,
// delete by key and clear. Depends on kcl_pkg and kcl_cell.
//
// Usage:
//   Input channel (in_valid/in_stall) carries op, key and payload; the output
//   channel (out_valid/out_stall) returns status and count, one result per
//   transaction, in order.
//   At the accept edge of a transaction every cell registers its key compare;
//   then, in the execute state, the first-match chain along the row of cells
//   selects the entries that shift up (or the tail slot that is written) and
//   the result register loads. The registered compare ahead of the first-match
//   chain means a new transaction is accepted only once the current one has
//   executed.
//   A new transaction is accepted while a finished result still waits on
//   out_stall; it then holds in the execute state until the result register
//   frees, and in_stall stays high meanwhile.
//   Reset empties the table (count 0) and clears out_valid; stored keys and
//   payloads are not cleared. Count reports the entry count modulo 64.
`default_nettype none

module keyed_compacting_list #(
    parameter int CAPACITY = kcl_pkg::CAPACITY_D
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     op,
    input  wire logic [kcl_pkg::KEY_W-1:0]      key,
    input  wire logic [kcl_pkg::PAYLOAD_W-1:0]  payload,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          status,
    output logic [kcl_pkg::COUNT_W-1:0]         count
);
    import kcl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    fsm_t                  state_reg;
    fsm_t                  state_next;
    op_t                   op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [PAYLOAD_W-1:0]  payload_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               status_reg;
    status_t               status_next;
    logic [COUNT_W-1:0]    count_out_reg;
    logic [COUNT_W-1:0]    count_out_next;

    logic                  in_fire;
    logic                  exec_fire;
    logic                  found;
    logic                  full;
    cell_ctrl_t            ctrl;

    logic                  occ_w     [CAPACITY+1];
    logic                  hit_w     [CAPACITY+1];
    logic [KEY_W-1:0]      key_w     [CAPACITY+1];
    logic [PAYLOAD_W-1:0]  payload_w [CAPACITY+1];

    assign in_stall  = (state_reg != FSM_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign exec_fire = (state_reg == FSM_EXEC) && (!out_valid_reg || !out_stall);

    assign ctrl.cmp_en = in_fire;
    assign ctrl.upd_en = exec_fire;
    assign ctrl.op     = op_reg;

    assign hit_w[0]            = 1'b0;
    assign occ_w[CAPACITY]     = 1'b0;
    assign key_w[CAPACITY]     = '0;
    assign payload_w[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic prev_occ;
        if (i == 0)
        begin : g_head
            assign prev_occ = 1'b1;
        end
        else
        begin : g_body
            assign prev_occ = occ_w[i-1];
        end

        kcl_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .cmp_key      (key),
            .wr_key       (key_reg),
            .wr_payload   (payload_reg),
            .prev_occ     (prev_occ),
            .next_occ     (occ_w[i+1]),
            .next_key     (key_w[i+1]),
            .next_payload (payload_w[i+1]),
            .hit_in       (hit_w[i]),
            .hit_out      (hit_w[i+1]),
            .occ          (occ_w[i]),
            .key_q        (key_w[i]),
            .payload_q    (payload_w[i])
        );
    end

    assign found = hit_w[CAPACITY];
    assign full  = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        count_out_next = count_out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            FSM_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (exec_fire)
                begin
                    status_next = STAT_DONE;
                    case (op_reg)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (found)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    count_out_next = COUNT_W'(count_next);
                    out_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= op_t'(op);
            key_reg     <= key;
            payload_reg <= payload;
        end
        status_reg    <= status_next;
        count_out_reg <= count_out_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;

endmodule

`default_nettype wire
